@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the core RTL.
// Each macro needs clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SWM_ASSERT(label, prop, msg)
`define SWM_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

@@ rtl/core/swm_pkg.sv @@
// Types, sizes and helper functions for the sliding window maximum core.
// No dependencies; used by every other core file but assert_macros.svh.
package swm_pkg;

    localparam int DEPTH       = 64;   // cells in the chain, largest window
    localparam int SAMPLE_W    = 16;
    localparam int POS_W       = 32;
    localparam int WSIZE_W     = 7;
    localparam int WSIZE_RESET = 3;
    localparam int L1_N        = DEPTH / 4;
    localparam int L2_N        = DEPTH / 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [WSIZE_W-1:0]         wsize_t;

    typedef struct packed {
        logic    valid;
        sample_t value;
    } entry_t;

    typedef struct packed {
        logic    shift;
        logic    clear;
        sample_t sample;
    } cell_ctl_t;

    // Larger of two entries; an invalid entry never wins over a valid one.
    function automatic entry_t pick_max(input entry_t a, input entry_t b);
        entry_t r;
        if (a.valid && (!b.valid || (a.value >= b.value)))
        begin
            r = a;
        end
        else
        begin
            r = b;
        end
        return r;
    endfunction

    function automatic entry_t pick_max4(input entry_t a, input entry_t b,
                                         input entry_t c, input entry_t d);
        return pick_max(pick_max(a, b), pick_max(c, d));
    endfunction

endpackage

@@ rtl/core/swm_in_if.sv @@
// Sample channel: valid/ready handshake carrying one sample word.
// Depends on swm_pkg for the sample type.
interface swm_in_if;
    logic             valid;
    logic             ready;
    swm_pkg::sample_t sample;
    logic             first_of_sequence;

    modport source (output valid, output sample, output first_of_sequence, input ready);
    modport sink   (input valid, input sample, input first_of_sequence, output ready);
endinterface

@@ rtl/core/swm_out_if.sv @@
// Result channel: valid/ready handshake carrying window maximum and start.
// Depends on swm_pkg for the payload types.
interface swm_out_if;
    logic             valid;
    logic             ready;
    swm_pkg::sample_t window_max;
    swm_pkg::pos_t    window_start;

    modport source (output valid, output window_max, output window_start, input ready);
    modport sink   (input valid, input window_max, input window_start, output ready);
endinterface

@@ rtl/core/sliding_window_max_deque.sv @@
// Sliding window maximum over a signed sample stream.
// Channels: samples (sink) takes one word per accepted handshake: sample and
// first_of_sequence, which restarts the window and the position count.
// maxima (source) gives window_max and window_start for each sample once the
// window has filled; samples before that give no word.
// cfg_we/cfg_wdata write window_size (0 acts as 1, above 64 acts as 64).
// Throughput: one sample per cycle while maxima is not stalled. The deque is
// a chain of 64 cells, one per sample age, all updated in the cycle a sample
// is accepted. Results pass through the three register stages of the maximum
// tree that reads the cell chain before maxima.valid rises.
// Reset clears all cells, the position counter and the wrap flag, and sets
// window_size to 3. No clearing pass is needed.
// A stall on maxima freezes the whole pipeline and drops samples.ready in
// the same cycle; the pending word holds until taken.
// Depends on swm_pkg, swm_in_if, swm_out_if, swm_cell, swm_max_tree.
`include "assert_macros.svh"
module sliding_window_max_deque (
    input  logic                  clk,
    input  logic                  rst_n,
    swm_in_if.sink                samples,
    swm_out_if.source             maxima,
    input  logic                  cfg_we,
    input  swm_pkg::wsize_t       cfg_wdata
);

    swm_pkg::wsize_t    wsize_reg;
    swm_pkg::wsize_t    k_eff;
    swm_pkg::pos_t      pos_reg;
    logic               wrapped_reg;
    swm_pkg::pos_t      pos_cur;
    logic               wrapped_cur;
    logic               emit;
    swm_pkg::pos_t      start_cur;

    logic               advance;
    logic               accept;

    logic               s0_valid_reg, s1_valid_reg, s2_valid_reg, out_valid_reg;
    swm_pkg::pos_t      s0_start_reg, s1_start_reg, s2_start_reg, out_start_reg;

    swm_pkg::cell_ctl_t cell_ctl [swm_pkg::DEPTH];
    swm_pkg::entry_t    cell_up  [swm_pkg::DEPTH];
    swm_pkg::entry_t    cell_q   [swm_pkg::DEPTH];
    logic [swm_pkg::DEPTH-1:0] age_ok;
    logic [swm_pkg::DEPTH-1:0] cell_valid;
    swm_pkg::entry_t    tree_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg <= swm_pkg::WSIZE_W'(swm_pkg::WSIZE_RESET);
        end
        else if (cfg_we)
        begin
            wsize_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        priority if (wsize_reg == '0)
        begin
            k_eff = swm_pkg::WSIZE_W'(1);
        end
        else if (wsize_reg > swm_pkg::WSIZE_W'(swm_pkg::DEPTH))
        begin
            k_eff = swm_pkg::WSIZE_W'(swm_pkg::DEPTH);
        end
        else
        begin
            k_eff = wsize_reg;
        end
    end

    assign advance       = !out_valid_reg || maxima.ready;
    assign samples.ready = advance;
    assign accept        = samples.valid && advance;

    // position of this sample, restarted by first_of_sequence
    assign pos_cur     = samples.first_of_sequence ? '0 : pos_reg;
    assign wrapped_cur = samples.first_of_sequence ? 1'b0 : wrapped_reg;
    assign emit        = wrapped_cur || (pos_cur >= (swm_pkg::POS_W'(k_eff) - 1'b1));
    assign start_cur   = pos_cur - swm_pkg::POS_W'(k_eff) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_cur + 1'b1;
            wrapped_reg <= wrapped_cur || (pos_cur == '1);
        end
    end

    // cell j holds the sample of age j; cell 0 takes the new sample
    always_comb
    begin
        for (int j = 0; j < swm_pkg::DEPTH; j++)
        begin
            cell_ctl[j].shift  = accept;
            cell_ctl[j].clear  = (j != 0) && samples.first_of_sequence;
            cell_ctl[j].sample = samples.sample;
            age_ok[j]          = swm_pkg::WSIZE_W'(j) < k_eff;
            cell_valid[j]      = cell_q[j].valid;
            if (j == 0)
            begin
                cell_up[j].valid = 1'b1;
                cell_up[j].value = samples.sample;
            end
            else
            begin
                cell_up[j] = cell_q[j-1];
            end
        end
    end

    for (genvar j = 0; j < swm_pkg::DEPTH; j++)
    begin : g_cell
        swm_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (cell_ctl[j]),
            .age_ok (age_ok[j]),
            .up     (cell_up[j]),
            .cur    (cell_q[j])
        );
    end

    swm_max_tree u_tree (
        .clk     (clk),
        .advance (advance),
        .leaves  (cell_q),
        .root    (tree_root)
    );

    // word flags and start positions travel alongside the tree stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg  <= accept && emit;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_start_reg  <= start_cur;
            s1_start_reg  <= s0_start_reg;
            s2_start_reg  <= s1_start_reg;
            out_start_reg <= s2_start_reg;
        end
    end

    assign maxima.valid        = out_valid_reg;
    assign maxima.window_max   = tree_root.value;
    assign maxima.window_start = out_start_reg;

    `SWM_ASSERT_NEXT(a_newest_kept, accept, cell_q[0].valid, "newest sample not kept in cell 0")
    `SWM_ASSERT_NEXT(a_first_clears, accept && samples.first_of_sequence,
        $countones(cell_valid) == 1, "first_of_sequence left stale cells")
    `SWM_ASSERT(a_root_valid, out_valid_reg |-> tree_root.valid, "result word without a maximum")
    `SWM_ASSERT(a_wrap_zero, $rose(wrapped_reg) |-> (pos_reg == '0), "wrap flag set off zero")

endmodule

@@ rtl/core/swm_cell.sv @@
// One deque cell: holds the sample of a fixed age and its keep flag.
// Depends on swm_pkg.
module swm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  swm_pkg::cell_ctl_t ctl,
    input  logic               age_ok,
    input  swm_pkg::entry_t    up,
    output swm_pkg::entry_t    cur
);

    logic             valid_reg;
    logic             valid_next;
    swm_pkg::sample_t value_reg;

    // drop when cleared, when too old or invalid, or when strictly smaller than the new sample
    assign valid_next = !ctl.clear && up.valid && age_ok && !(up.value < ctl.sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            value_reg <= up.value;
        end
    end

    assign cur.valid = valid_reg;
    assign cur.value = value_reg;

endmodule

@@ rtl/core/swm_max_tree.sv @@
// Three-stage registered 4-ary maximum tree over the cell chain.
// Depends on swm_pkg.
module swm_max_tree (
    input  logic            clk,
    input  logic            advance,
    input  swm_pkg::entry_t leaves [swm_pkg::DEPTH],
    output swm_pkg::entry_t root
);

    swm_pkg::entry_t l1_reg [swm_pkg::L1_N];
    swm_pkg::entry_t l2_reg [swm_pkg::L2_N];
    swm_pkg::entry_t root_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < swm_pkg::L1_N; i++)
            begin
                l1_reg[i] <= swm_pkg::pick_max4(leaves[4*i], leaves[4*i+1],
                                                leaves[4*i+2], leaves[4*i+3]);
            end
            for (int i = 0; i < swm_pkg::L2_N; i++)
            begin
                l2_reg[i] <= swm_pkg::pick_max4(l1_reg[4*i], l1_reg[4*i+1],
                                                l1_reg[4*i+2], l1_reg[4*i+3]);
            end
            root_reg <= swm_pkg::pick_max4(l2_reg[0], l2_reg[1], l2_reg[2], l2_reg[3]);
        end
    end

    assign root = root_reg;

endmodule
